@@ hw/rtl/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, constants and helpers for the stream find-and-replace block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int CNT_W           = 4;   // holds 0..8
    localparam int JOB_DEPTH       = 4;
    localparam int JOB_PTR_W       = 2;
    localparam int JOB_CNT_W       = 3;

    typedef enum logic [1:0] {
        CFG_PATTERN_BYTES     = 2'd0,
        CFG_PATTERN_LEN       = 2'd1,
        CFG_REPLACEMENT_BYTES = 2'd2,
        CFG_REPLACEMENT_LEN   = 2'd3
    } cfg_reg_t;

    // effective configuration, lengths already clamped
    typedef struct packed {
        logic [63:0]      pattern;
        logic [CNT_W-1:0] plen;
        logic [63:0]      repl;
        logic [CNT_W-1:0] rlen;
    } cfg_t;

    // one unit of output work: n bytes from pattern or replacement,
    // then optionally the literal byte c
    typedef struct packed {
        logic             sel_repl;
        logic [CNT_W-1:0] n;
        logic             with_c;
        logic [7:0]       c;
        logic             eos;
    } job_t;

    function automatic logic [7:0] sel_byte(input logic [63:0] word, input logic [2:0] idx);
        logic [5:0] base;
        base = {idx, 3'b000};
        return word[base +: 8];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/stream_find_and_replace.sv @@
// ----------------------------------------------------------------------------
// stream_find_and_replace
// Streaming fixed-pattern find and replace over byte strings.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     push / full             data_byte, end_of_string
//  result    empty / pop             out_byte, out_has_byte, out_last
//  config    cfg_wr_en (no stall)    cfg_addr, cfg_wdata
//
//  one input beat per cycle while the job queue has room; the prefix tracker
//  updates its registered pending count once per accepted byte
//  the emitter sends one result beat per cycle unless an unpopped result is held,
//  so a byte that releases n bytes keeps it busy n beats; bursts are
//  absorbed by a 4-entry job queue and the input stalls (full) only once
//  that queue fills; each job passes the queue, then the output register
//  reset clears pending count, queue pointers, output valid and config regs
// ----------------------------------------------------------------------------
`default_nettype none

module stream_find_and_replace
    import sfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_string,
    // result stream
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_byte,
    output logic             out_has_byte,
    output logic             out_last,
    // configuration writes
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [63:0] cfg_wdata
);

    // configuration registers
    logic [63:0]      pattern_bytes_reg;
    logic [CNT_W-1:0] pattern_len_reg;
    logic [63:0]      replacement_bytes_reg;
    logic [CNT_W-1:0] replacement_len_reg;

    cfg_t     cfg;
    cfg_reg_t cfg_sel;
    logic     pattern_clear;

    // front to queue to back
    logic job_push;
    job_t job;
    logic job_full;
    logic head_valid;
    job_t head;
    logic job_pop;

    assign cfg_sel = cfg_reg_t'(cfg_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg     <= '0;
            pattern_len_reg       <= '0;
            replacement_bytes_reg <= '0;
            replacement_len_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_sel)
                CFG_PATTERN_BYTES:     pattern_bytes_reg     <= cfg_wdata;
                CFG_PATTERN_LEN:       pattern_len_reg       <= cfg_wdata[CNT_W-1:0];
                CFG_REPLACEMENT_BYTES: replacement_bytes_reg <= cfg_wdata;
                CFG_REPLACEMENT_LEN:   replacement_len_reg   <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // rewriting the pattern drops any held prefix
    assign pattern_clear = cfg_wr_en
                        && (cfg_sel == CFG_PATTERN_BYTES || cfg_sel == CFG_PATTERN_LEN);

    // lengths above the maximum are taken as the maximum
    always_comb
    begin
        cfg.pattern = pattern_bytes_reg;
        cfg.repl    = replacement_bytes_reg;
        cfg.plen    = (pattern_len_reg > CNT_W'(MAX_PATTERN))
                    ? CNT_W'(MAX_PATTERN) : pattern_len_reg;
        cfg.rlen    = (replacement_len_reg > CNT_W'(MAX_REPLACEMENT))
                    ? CNT_W'(MAX_REPLACEMENT) : replacement_len_reg;
    end

    // classify each byte against the pattern, emit a job description
    sfr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .pattern_clear (pattern_clear),
        .push          (push),
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .full          (full),
        .job_full      (job_full),
        .job_push      (job_push),
        .job           (job)
    );

    // decouples the byte classifier from the burst emitter
    sfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (job_push),
        .wr_job     (job),
        .full       (job_full),
        .head_valid (head_valid),
        .head       (head),
        .rd_en      (job_pop)
    );

    // expand jobs into result beats through the output register
    sfr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head_valid   (head_valid),
        .head         (head),
        .job_pop      (job_pop),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .out_has_byte (out_has_byte),
        .out_last     (out_last)
    );

endmodule

`default_nettype wire

@@ hw/rtl/sfr_front.sv @@
// ----------------------------------------------------------------------------
// sfr_front
// Prefix tracker: takes one byte per cycle while not full, turns it into a job.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_front
    import sfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       pattern_clear,
    input  wire logic       push,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_string,
    output logic            full,
    input  wire logic       job_full,
    output logic            job_push,
    output job_t            job
);

    logic [CNT_W-1:0] pend_reg;
    logic [CNT_W-1:0] pend_next;

    logic             accept;
    logic [CNT_W-1:0] k;
    logic [7:0]       pat_k;
    logic             hit;
    logic [7:0][7:0]  border;
    logic [7:0]       cand;
    logic [CNT_W-1:0] j;
    logic             has_job;

    assign full   = job_full;
    assign accept = push && !job_full;

    // border[kk][jj]: pattern[kk+1-jj .. kk-1] equals pattern[0 .. jj-2]
    always_comb
    begin
        border = '0;
        for (int kk = 0; kk < MAX_PATTERN; kk++)
        begin
            for (int jj = 1; jj <= kk; jj++)
            begin
                border[kk][jj] = 1'b1;
                for (int i = 0; i < jj - 1; i++)
                begin
                    if (cfg.pattern[8*(kk+1-jj+i) +: 8] != cfg.pattern[8*i +: 8])
                        border[kk][jj] = 1'b0;
                end
            end
        end
    end

    assign k     = (pend_reg >= cfg.plen) ? '0 : pend_reg;
    assign pat_k = sel_byte(cfg.pattern, k[2:0]);
    assign hit   = (pat_k == data_byte);

    // fallback length: longest kept suffix that is still a pattern prefix
    always_comb
    begin
        cand = '0;
        j    = '0;
        for (int jj = 1; jj < MAX_PATTERN; jj++)
        begin
            cand[jj] = (CNT_W'(jj) <= k)
                    && (cfg.pattern[8*(jj-1) +: 8] == data_byte)
                    && border[k[2:0]][jj];
            if (cand[jj])
                j = CNT_W'(jj);
        end
    end

    always_comb
    begin
        job          = '0;
        job.c        = data_byte;
        job.eos      = end_of_string;
        has_job      = 1'b1;
        pend_next    = pend_reg;
        if (accept)
        begin
            priority if (cfg.plen == '0)
            begin
                job.with_c = 1'b1;
                pend_next  = '0;
            end
            else if (hit && (k + 4'd1 == cfg.plen))
            begin
                job.sel_repl = 1'b1;
                job.n        = cfg.rlen;
                has_job      = (cfg.rlen != '0) || end_of_string;
                pend_next    = '0;
            end
            else if (end_of_string)
            begin
                // flush: held prefix then the byte itself
                job.n      = k;
                job.with_c = 1'b1;
                pend_next  = '0;
            end
            else if (hit)
            begin
                has_job   = 1'b0;
                pend_next = k + 4'd1;
            end
            else if (j == '0)
            begin
                job.n      = k;
                job.with_c = 1'b1;
                pend_next  = '0;
            end
            else
            begin
                job.n     = k + 4'd1 - j;
                pend_next = j;
            end
        end
        if (pattern_clear)
            pend_next = '0;
    end

    assign job_push = accept && has_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

`ifndef NO_ASSERTIONS
    // held prefix never reaches the pattern length
    a_pend_short: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == '0 || pend_reg < cfg.plen)
        else $error("pending count not below pattern length");

    // pass-through mode always produces work for every accepted byte
    a_pass_job: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cfg.plen == '0 |-> job_push && job.with_c)
        else $error("pass-through byte dropped");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/sfr_queue.sv @@
// ----------------------------------------------------------------------------
// sfr_queue
// Short job queue between the prefix tracker and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_queue
    import sfr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire job_t wr_job,
    output logic      full,
    output logic      head_valid,
    output job_t      head,
    input  wire logic rd_en
);

    job_t                 slot_reg [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] wr_ptr_reg;
    logic [JOB_PTR_W-1:0] rd_ptr_reg;
    logic [JOB_CNT_W-1:0] count_reg;
    logic [JOB_CNT_W-1:0] count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign full       = (count_reg == JOB_CNT_W'(JOB_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_wr      = wr_en && !full;
    assign do_rd      = rd_en && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= JOB_CNT_W'(JOB_DEPTH))
        else $error("job queue overflow");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/sfr_back.sv @@
// ----------------------------------------------------------------------------
// sfr_back
// Emitter: walks jobs one byte per cycle into the output reg unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_back
    import sfr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  head_valid,
    input  wire job_t  head,
    output logic       job_pop,
    output logic       empty,
    input  wire logic  pop,
    output logic [7:0] out_byte,
    output logic       out_has_byte,
    output logic       out_last
);

    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             out_has_reg;
    logic             out_last_reg;

    logic [CNT_W-1:0] total;
    logic             bare;
    logic             last_el;
    logic             load;
    logic [7:0]       cur_byte;

    assign total   = head.n + {{(CNT_W-1){1'b0}}, head.with_c};
    assign bare    = (total == '0);
    assign last_el = bare || (idx_reg == total - 4'd1);
    assign load    = head_valid && (!out_valid_reg || pop);
    assign job_pop = load && last_el;

    always_comb
    begin
        priority if (bare)
            cur_byte = '0;
        else if (idx_reg < head.n)
            cur_byte = head.sel_repl ? sel_byte(cfg.repl, idx_reg[2:0])
                                     : sel_byte(cfg.pattern, idx_reg[2:0]);
        else
            cur_byte = head.c;
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = last_el ? '0 : idx_reg + 4'd1;
            out_valid_next = 1'b1;
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= cur_byte;
            out_has_reg  <= !bare;
            out_last_reg <= head.eos && last_el;
        end
    end

    assign empty        = !out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign out_has_byte = out_has_reg;
    assign out_last     = out_last_reg;

`ifndef NO_ASSERTIONS
    a_job_size: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> total <= CNT_W'(MAX_PATTERN))
        else $error("job larger than one burst");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg == '0 || idx_reg < total))
        else $error("emit index past job end");

    a_bare_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        load && bare |-> head.eos)
        else $error("bare marker outside end of string");
`endif

endmodule

`default_nettype wire
